[rtl/core/voxel_line_rasterizer_3d_top_macros.svh]
// Assertion macros shared by the rasterizer RTL.
// Each macro checks on the rising edge of aclk and stays quiet while aresetn is low.
`ifndef VOXEL_LINE_RASTERIZER_3D_TOP_MACROS_SVH
`define VOXEL_LINE_RASTERIZER_3D_TOP_MACROS_SVH

`ifndef SYNTHESIS

// When ante holds, cons must hold in the same cycle.
`define VLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define VLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VLR_ASSERT_IMP(lbl, ante, cons, msg)

`define VLR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/vlr3d_pkg.sv]
`default_nettype none

package vlr3d_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CAND_W     = 17;
    localparam int GEN_W      = 7;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CANDIDATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GENERATED = 2'd1;

    localparam logic [CAND_W-1:0] CAND_RESET = 17'd64;
    localparam logic [GEN_W-1:0]  GEN_RESET  = 7'd64;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_PLANNED    = 2'd0,
        STATUS_CAND_LIMIT = 2'd1,
        STATUS_GEN_LIMIT  = 2'd2
    } status_t;

    // m_tuser layout: present flag in bit 0, status above it.
    localparam int USER_W = 3;

endpackage

`default_nettype wire

[rtl/core/voxel_line_rasterizer_3d_top.sv]
`default_nettype none

// 3D Bresenham line rasterizer. Each input transaction carries two signed grid
// endpoints; the block orders them (lesser by z, then y, then x, as the start),
// finds the dominant axis (x on ties, then y) and emits every voxel of the line
// from start to end, one output transaction per voxel, with tlast on the final
// one. A line whose cell count exceeds max_candidate_cells, or else the smaller
// of max_generated_cells and MAX_CELLS, produces a single transaction with no
// cell and a nonzero status. A line is taken only while the block is idle,
// and then goes through these steps in order: the endpoints are ordered, one
// shared subtractor runs once per axis for the axis distances, the dominant
// axis is picked, the limits are checked, the subtractor runs once more per
// axis for the initial error terms, and then one cycle goes to each voxel (up
// to MAX_CELLS) while the output is not held back. A rejected line ends after
// the limit check, where its result waits while the output is held back.
// Configuration writes take effect at the clock edge that carries them.
module voxel_line_rasterizer_3d_top
    import vlr3d_pkg::*;
#(
    parameter int MAX_CELLS  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                  cfg_wdata,

    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
    input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,

    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // cell_x, cell_y, cell_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]           m_tdata,
    // cell_present, status
    output logic [USER_W-1:0]                           m_tuser,
    output logic                                        m_tlast
);

`include "voxel_line_rasterizer_3d_top_macros.svh"

    localparam int CB    = COORD_BITS;
    localparam int EW    = COORD_BITS + 3;
    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;
    localparam int LW    = (COORD_BITS > CAND_W) ? COORD_BITS : CAND_W;
    localparam int GW    = (COORD_BITS > GEN_W) ? COORD_BITS : GEN_W;
    localparam int KW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [GEN_W-1:0] GEN_CAP = GEN_W'(MAX_CELLS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORDER,
        ST_DIFF,
        ST_SELECT,
        ST_CHECK,
        ST_INIT,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CAND_W-1:0]      cand_reg, cand_next;
    logic [GEN_W-1:0]       gen_reg, gen_next;
    logic [1:0]             idx_reg, idx_next;
    logic [1:0]             major_reg, major_next;
    logic [CB-1:0]          n_reg, n_next;
    logic [KW-1:0]          remain_reg, remain_next;

    logic signed [CB-1:0]   s_reg [3];
    logic signed [CB-1:0]   s_next [3];
    logic signed [CB-1:0]   e_reg [3];
    logic signed [CB-1:0]   e_next [3];
    logic signed [CB-1:0]   p_reg [3];
    logic signed [CB-1:0]   p_next [3];
    logic [CB-1:0]          d_reg [3];
    logic [CB-1:0]          d_next [3];
    logic                   neg_reg [3];
    logic                   neg_next [3];
    logic signed [EW-1:0]   err_reg [3];
    logic signed [EW-1:0]   err_next [3];

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [USER_W-1:0]      m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    // Shared subtractor used for the axis distances and the initial errors.
    logic signed [EW-1:0]   op_a, op_b, unit_res;
    logic                   axis_lt;

    logic                   end_first;
    logic [GEN_W-1:0]       gen_eff;
    logic                   cand_over, gen_over;
    logic                   out_free;
    logic signed [EW-1:0]   two_n;

    assign axis_lt  = s_reg[idx_reg] < e_reg[idx_reg];
    assign unit_res = op_a - op_b;

    always_comb begin
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_DIFF) begin
            if (axis_lt) begin
                op_a = EW'(e_reg[idx_reg]);
                op_b = EW'(s_reg[idx_reg]);
            end else begin
                op_a = EW'(s_reg[idx_reg]);
                op_b = EW'(e_reg[idx_reg]);
            end
        end else begin
            op_a = $signed({2'b00, d_reg[idx_reg], 1'b0});
            op_b = $signed({3'b000, n_reg});
        end
    end

    // The end point is the start when it sorts lower by z, then y, then x.
    assign end_first = (e_reg[2] < s_reg[2]) ||
                       ((e_reg[2] == s_reg[2]) && (e_reg[1] < s_reg[1])) ||
                       ((e_reg[2] == s_reg[2]) && (e_reg[1] == s_reg[1]) &&
                        (e_reg[0] < s_reg[0]));

    assign gen_eff   = (gen_reg > GEN_CAP) ? GEN_CAP : gen_reg;
    // count = n + 1 exceeds a limit exactly when n is at least that limit.
    assign cand_over = LW'(n_reg) >= LW'(cand_reg);
    assign gen_over  = GW'(n_reg) >= GW'(gen_eff);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign two_n     = $signed({2'b00, n_reg, 1'b0});

    always_comb begin
        state_next    = state_reg;
        cand_next     = cand_reg;
        gen_next      = gen_reg;
        idx_next      = idx_reg;
        major_next    = major_reg;
        n_next        = n_reg;
        remain_next   = remain_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        p_next        = p_reg;
        d_next        = d_reg;
        neg_next      = neg_reg;
        err_next      = err_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_CANDIDATE: cand_next = cfg_wdata[CAND_W-1:0];
                REG_MAX_GENERATED: gen_next  = cfg_wdata[GEN_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int a = 0; a < 3; a++) begin
                        s_next[a] = s_tdata[a*CB +: CB];
                        e_next[a] = s_tdata[(a+3)*CB +: CB];
                    end
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER: begin
                if (end_first) begin
                    s_next = e_reg;
                    e_next = s_reg;
                    p_next = e_reg;
                end else begin
                    p_next = s_reg;
                end
                idx_next   = 2'd0;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                d_next[idx_reg]   = unit_res[CB-1:0];
                neg_next[idx_reg] = !axis_lt;
                if (idx_reg == 2'd2) begin
                    state_next = ST_SELECT;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_SELECT: begin
                if (d_reg[0] >= d_reg[1] && d_reg[0] >= d_reg[2]) begin
                    major_next = 2'd0;
                    n_next     = d_reg[0];
                end else if (d_reg[1] >= d_reg[2]) begin
                    major_next = 2'd1;
                    n_next     = d_reg[1];
                end else begin
                    major_next = 2'd2;
                    n_next     = d_reg[2];
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (cand_over || gen_over) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = {cand_over ? STATUS_CAND_LIMIT : STATUS_GEN_LIMIT,
                                         1'b0};
                        m_tlast_next  = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    remain_next = KW'(n_reg);
                    idx_next    = 2'd0;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT: begin
                err_next[idx_reg] = unit_res;
                if (idx_reg == 2'd2) begin
                    state_next = ST_EMIT;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({p_reg[2], p_reg[1], p_reg[0]});
                    m_tuser_next  = {STATUS_PLANNED, 1'b1};
                    m_tlast_next  = (remain_reg == '0);
                    for (int a = 0; a < 3; a++) begin
                        if (2'(a) == major_reg) begin
                            p_next[a] = p_reg[a] + (neg_reg[a] ? -CB'(1) : CB'(1));
                        end else if (err_reg[a] >= 0) begin
                            p_next[a]   = p_reg[a] + (neg_reg[a] ? -CB'(1) : CB'(1));
                            err_next[a] = err_reg[a] - two_n +
                                          $signed({2'b00, d_reg[a], 1'b0});
                        end else begin
                            err_next[a] = err_reg[a] + $signed({2'b00, d_reg[a], 1'b0});
                        end
                    end
                    remain_next = remain_reg - KW'(1);
                    if (remain_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        major_reg   <= major_next;
        n_reg       <= n_next;
        remain_reg  <= remain_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cand_reg     <= CAND_RESET;
            gen_reg      <= GEN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cand_reg     <= cand_next;
            gen_reg      <= gen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `VLR_ASSERT_IMP(a_reject_is_last, m_tvalid && !m_tuser[0], m_tlast,
        "Result without a cell is not marked last.")
    `VLR_ASSERT_IMP(a_reject_zero_cell, m_tvalid && !m_tuser[0], m_tdata == '0,
        "Result without a cell carries nonzero coordinates.")
    `VLR_ASSERT_IMP(a_cell_planned, m_tvalid && m_tuser[0],
        m_tuser[2:1] == STATUS_PLANNED, "Voxel result carries a reject status.")
    `VLR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "Input accepted again before the current line was processed.")

endmodule

`default_nettype wire

[verif/voxel_line_rasterizer_3d_top_tb.sv]
`timescale 1ns / 1ps

module voxel_line_rasterizer_3d_top_tb
    import vlr3d_pkg::*;
();

    localparam int MAX_CELLS     = 64;
    localparam int COORD_BITS    = 16;
    localparam int LINE_W        = 6 * COORD_BITS;
    localparam int VOXEL_W       = 3 * COORD_BITS;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_LIMIT  = 10;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    localparam logic [CFG_DATA_W-1:0] CAND_MAX      = 17'd65536;
    localparam logic [CFG_DATA_W-1:0] DATA_ALL_ONES = '1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        logic    present;
        status_t status;
        logic    last;
    } voxel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z
    logic [LINE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // cell_x, cell_y, cell_z
    logic [VOXEL_W-1:0]    m_tdata;
    // cell_present, status
    logic [USER_W-1:0]     m_tuser;
    logic                  m_tlast;

    logic [CAND_W-1:0] cand_limit;
    logic [GEN_W-1:0]  gen_limit;
    voxel_t            expected_voxels[$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;
    int                stall_left     = 0;
    bit                source_gaps;
    bit                sink_stalls;

    voxel_line_rasterizer_3d_top #(
        .MAX_CELLS (MAX_CELLS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void queue_expected(input voxel_t v);
        expected_voxels.insert(expected_voxels.size(), v);
    endfunction

    // Works out the voxels of one line, or its single rejection result.
    function automatic void rasterize_line(input logic [LINE_W-1:0] line);
        longint head[3], tail[3], delta[3], dir[3], cur[3], err[3];
        longint span, cells, cap, tmp, k;
        int     a, major;
        voxel_t v;
        for (a = 0; a < 3; a++) begin
            head[a] = coord_t'(line[a*COORD_BITS +: COORD_BITS]);
            tail[a] = coord_t'(line[(a+3)*COORD_BITS +: COORD_BITS]);
        end
        if (tail[2] < head[2] || (tail[2] == head[2] && (tail[1] < head[1] ||
            (tail[1] == head[1] && tail[0] < head[0])))) begin
            for (a = 0; a < 3; a++) begin
                tmp     = head[a];
                head[a] = tail[a];
                tail[a] = tmp;
            end
        end
        for (a = 0; a < 3; a++) begin
            delta[a] = (tail[a] > head[a]) ? tail[a] - head[a] : head[a] - tail[a];
            dir[a]   = (head[a] < tail[a]) ? 1 : -1;
            cur[a]   = head[a];
        end
        if (delta[0] >= delta[1] && delta[0] >= delta[2]) major = 0;
        else if (delta[1] >= delta[2]) major = 1;
        else major = 2;
        span  = delta[major];
        cells = span + 1;
        cap   = (gen_limit > MAX_CELLS) ? MAX_CELLS : gen_limit;

        v      = '0;
        v.last = 1'b1;
        if (cells > cand_limit) begin
            v.status = STATUS_CAND_LIMIT;
            queue_expected(v);
            return;
        end
        if (cells > cap) begin
            v.status = STATUS_GEN_LIMIT;
            queue_expected(v);
            return;
        end

        for (a = 0; a < 3; a++) err[a] = 2 * delta[a] - span;
        for (k = 0; k < cells; k++) begin
            v.x       = coord_t'(cur[0]);
            v.y       = coord_t'(cur[1]);
            v.z       = coord_t'(cur[2]);
            v.present = 1'b1;
            v.status  = STATUS_PLANNED;
            v.last    = (k == cells - 1);
            queue_expected(v);
            for (a = 0; a < 3; a++) begin
                if (a != major) begin
                    if (err[a] >= 0) begin
                        cur[a] += dir[a];
                        err[a] -= 2 * span;
                    end
                    err[a] += 2 * delta[a];
                end
            end
            cur[major] += dir[major];
        end
    endfunction

    task automatic report_voxel(input string what, input voxel_t want, input voxel_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s: expected x=%0d y=%0d z=%0d present=%0b status=%0d last=%0b",
                     what, want.x, want.y, want.z, want.present, want.status, want.last);
            $display("    got x=%0d y=%0d z=%0d present=%0b status=%0d last=%0b",
                     got.x, got.y, got.z, got.present, got.status, got.last);
        end
    endtask

    always @(posedge aclk) begin
        voxel_t got;
        voxel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x       = m_tdata[COORD_BITS-1:0];
            got.y       = m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.z       = m_tdata[3*COORD_BITS-1:2*COORD_BITS];
            got.present = m_tuser[0];
            got.status  = status_t'(m_tuser[2:1]);
            got.last    = m_tlast;
            if (expected_voxels.size() == 0) begin
                report_voxel("unexpected voxel transaction", '0, got);
            end else begin
                want = expected_voxels.pop_front();
                if (got !== want) report_voxel("voxel mismatch", want, got);
            end
        end
    end

    // Random backpressure in bursts while sink_stalls is set.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("voxel_line_rasterizer_3d_top_tb NOT OK");
            $finish;
        end
    end

    task automatic send_line(input coord_t ax, ay, az, bx, by, bz);
        s_tvalid <= 1'b1;
        s_tdata  <= {bz, by, bx, az, ay, ax};
        do @(posedge aclk); while (!s_tready);
        rasterize_line({bz, by, bx, az, ay, ax});
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Lets every expected voxel drain, then gives the block time to go idle.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_voxels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_CANDIDATE) cand_limit = data[CAND_W-1:0];
        else if (idx == REG_MAX_GENERATED) gen_limit = data[GEN_W-1:0];
        @(posedge aclk);
    endtask

    task automatic send_random_line();
        coord_t base[3];
        coord_t other[3];
        int     a;
        int     reach;
        int     pick;
        reach = ($urandom_range(0, 3) == 0) ? 70 : 12;
        for (a = 0; a < 3; a++) base[a] = coord_t'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                for (a = 0; a < 3; a++) other[a] = coord_t'($urandom);
            end
            9: begin
                // Line along one axis only.
                other = base;
                pick  = $urandom_range(0, 2);
                other[pick] = base[pick] + coord_t'($urandom_range(0, 140)) - coord_t'(70);
            end
            default: begin
                for (a = 0; a < 3; a++) begin
                    other[a] = base[a] + coord_t'($urandom_range(0, 2 * reach))
                               - coord_t'(reach);
                end
            end
        endcase
        send_line(base[0], base[1], base[2], other[0], other[1], other[2]);
    endtask

    task automatic test_endpoint_ordering();
        send_line(5, 0, 3, 1, 0, -2);
        send_line(2, 7, 4, 9, -3, 4);
        send_line(6, 1, 1, -5, 1, 1);
        send_line(-3, -3, -3, 4, 4, 4);
        settle_block();
    endtask

    task automatic test_dominant_axis();
        send_line(0, 0, 0, 5, 5, 2);
        send_line(0, 0, 0, 3, 9, 9);
        send_line(0, 0, 0, 2, -4, 11);
        send_line(10, -10, 0, -2, 3, -1);
        settle_block();
    endtask

    task automatic test_field_extremes();
        send_line(-32768, -32768, -32768, -32768, -32768, -32768);
        send_line(32767, 32767, 32767, 32767, 32767, 32767);
        send_line(-32768, 32767, -32768, 32767, -32768, 32767);
        // Longest line the default limits allow, then one cell more.
        send_line(32704, 32767, -32768, 32767, 32757, -32738);
        send_line(-32768, 0, 100, -32704, 20, 90);
        settle_block();
    endtask

    task automatic test_candidate_limit();
        configure(REG_MAX_CANDIDATE, '0);
        send_line(7, 7, 7, 7, 7, 7);
        send_line(0, 0, 0, 3, 1, 0);
        settle_block();
        configure(REG_MAX_CANDIDATE, 17'd1);
        send_line(-9, 4, 2, -9, 4, 2);
        send_line(-9, 4, 2, -8, 4, 2);
        settle_block();
    endtask

    task automatic test_generated_limit();
        configure(REG_MAX_CANDIDATE, CAND_MAX);
        configure(REG_MAX_GENERATED, '0);
        send_line(1, 2, 3, 1, 2, 3);
        settle_block();
        configure(REG_MAX_GENERATED, 17'd1);
        send_line(1, 2, 3, 1, 2, 3);
        settle_block();
        // Upper bits of the write data are dropped; the register holds 127, so MAX_CELLS acts as the capacity.
        configure(REG_MAX_GENERATED, DATA_ALL_ONES);
        send_line(0, 0, 0, -63, 20, 5);
        send_line(0, 0, 0, 0, 0, 64);
        send_line(-32768, -32768, -32768, 32767, 32767, 32767);
        settle_block();
    endtask

    task automatic test_unknown_index();
        configure(REG_MAX_CANDIDATE, 17'd64);
        configure(REG_MAX_GENERATED, 17'd64);
        configure(REG_UNMAPPED_LO, '0);
        configure(REG_UNMAPPED_HI, '0);
        send_line(-4, 3, 0, 5, -6, 7);
        settle_block();
    endtask

    task automatic test_random_lines(input int lines, input logic [CFG_DATA_W-1:0] cand,
                                     input logic [CFG_DATA_W-1:0] gen);
        configure(REG_MAX_CANDIDATE, cand);
        configure(REG_MAX_GENERATED, gen);
        repeat (lines) send_random_line();
        settle_block();
    endtask

    task automatic test_steady_stream();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_lines(60, CAND_MAX, 17'd64);
    endtask

    initial begin
        cand_limit  = CAND_RESET;
        gen_limit   = GEN_RESET;
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_endpoint_ordering();
        test_dominant_axis();
        test_field_extremes();
        test_candidate_limit();
        test_generated_limit();
        test_unknown_index();
        test_random_lines(100, CAND_MAX, 17'd64);
        test_random_lines(100, 17'($urandom_range(1, 80)), 17'($urandom_range(1, 64)));
        test_random_lines(100, 17'd64, DATA_ALL_ONES);
        test_steady_stream();

        if (mismatch_count == 0 && expected_voxels.size() == 0) begin
            $display("voxel_line_rasterizer_3d_top_tb OK");
        end else begin
            $display("voxel_line_rasterizer_3d_top_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/vlr3d_pkg.sv
rtl/core/voxel_line_rasterizer_3d_top.sv
verif/voxel_line_rasterizer_3d_top_tb.sv
